// ===== sv/ppc_pkg.sv =====
// Shared types, constants and datapath step functions for the disc collision pipeline.
package ppc_pkg;

  localparam int FW      = 24;  // field width
  localparam int DW      = 25;  // coordinate difference width
  localparam int RTW     = 21;  // root / distance width
  localparam int SRW     = 24;  // square root partial remainder width
  localparam int D2W     = 42;  // squared distance width inside contact range
  localparam int NW      = 48;  // dividend width
  localparam int QW      = 28;  // quotient width, one bit per stage
  localparam int SUMW    = 30;  // width for final add before saturation
  localparam int NDIV    = 3;   // dividers per divide segment
  localparam logic [9:0] REST_ONE = 10'd256;

  localparam logic [19:0] RADIUS_RESET = 20'd1280;
  localparam logic [8:0]  REST_RESET   = 9'd256;

  typedef enum logic {
    REG_DISC_RADIUS,
    REG_RESTITUTION
  } reg_idx_t;

  typedef logic signed [FW-1:0] fld_t;

  typedef struct packed {
    logic signed [FW-1:0] p1x;
    logic signed [FW-1:0] p1y;
    logic signed [FW-1:0] v1x;
    logic signed [FW-1:0] v1y;
    logic signed [FW-1:0] p2x;
    logic signed [FW-1:0] p2y;
    logic signed [FW-1:0] v2x;
    logic signed [FW-1:0] v2y;
  } discs_t;

  // square root segment stage
  typedef struct packed {
    discs_t               d;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 ct;
    logic [D2W-1:0]       n;
    logic signed [NW-1:0] dot;
    logic [SRW-1:0]       rem;
    logic [RTW-1:0]       root;
  } sq_t;

  typedef struct packed {
    logic [SRW-1:0] rem;
    logic [RTW-1:0] root;
  } sqs_t;

  // divide segment stage: up to three quotients against the same distance
  typedef struct packed {
    discs_t                   d;
    logic                     sx;
    logic                     sy;
    logic                     ct;
    logic [RTW-1:0]           dxm;
    logic [RTW-1:0]           dym;
    logic [RTW-1:0]           dnorm;
    logic [RTW-1:0]           cx;
    logic [RTW-1:0]           cy;
    logic [NDIV-1:0][NW-1:0]  n;
    logic [NDIV-1:0][RTW-1:0] r;
    logic [NDIV-1:0][QW-1:0]  q;
  } dv_t;

  typedef struct packed {
    logic [RTW-1:0] r;
    logic           qb;
  } dvs_t;

  // one digit of the bitwise integer square root
  function automatic sqs_t sqrt_step(input logic [SRW-1:0] rem, input logic [RTW-1:0] root,
                                     input logic [1:0] pair);
    logic [SRW-1:0] cur;
    logic [SRW-1:0] trial;
    sqs_t           res;
    cur   = {rem[SRW-3:0], pair};
    trial = {1'b0, root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {root[RTW-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {root[RTW-2:0], 1'b0};
    end
    return res;
  endfunction

  // one restoring division step
  function automatic dvs_t div_step(input logic [RTW-1:0] r, input logic nb,
                                    input logic [RTW-1:0] d);
    logic [RTW:0] t;
    logic [RTW:0] diff;
    dvs_t         res;
    t    = {r, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      res.r  = diff[RTW-1:0];
      res.qb = 1'b1;
    end else begin
      res.r  = t[RTW-1:0];
      res.qb = 1'b0;
    end
    return res;
  endfunction

  function automatic fld_t sat(input logic signed [SUMW-1:0] x);
    fld_t res;
    if (x > SUMW'(signed'(24'sh7FFFFF))) begin
      res = 24'sh7FFFFF;
    end else if (x < SUMW'(signed'(24'sh800000))) begin
      res = 24'sh800000;
    end else begin
      res = x[FW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/particle_pair_collision_top.sv =====
// Pipelined equal-mass 2D disc collision resolver with APB configuration.
//
// Usage: drive the eight input fields and raise start; a request is taken at
// every rising edge with start high and busy low. busy is always low, so one
// pair may be issued every cycle. Each result appears on the result ports for
// exactly one cycle with done high, in request order. The receiver cannot
// stall the block and needs no handshake. The pipeline holds a 21-stage square
// root (one root bit per stage) and two 28-stage restoring divide segments
// (one quotient bit per stage), plus multiply, add and saturate stages.
// Throughput is one pair per cycle.
// Configuration: APB, disc_radius at address 0, restitution at address 4;
// pready is always high and reads return the register value. Write only when
// no request is in flight.
// Reset (rst, synchronous) clears all valid bits, so nothing in flight is
// delivered, and loads radius 1280 and restitution 256.
module particle_pair_collision_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] first_pos_x,
  input  logic signed [23:0] first_pos_y,
  input  logic signed [23:0] first_vel_x,
  input  logic signed [23:0] first_vel_y,
  input  logic signed [23:0] second_pos_x,
  input  logic signed [23:0] second_pos_y,
  input  logic signed [23:0] second_vel_x,
  input  logic signed [23:0] second_vel_y,
  output logic               done,
  output logic signed [23:0] new_first_pos_x,
  output logic signed [23:0] new_first_pos_y,
  output logic signed [23:0] new_first_vel_x,
  output logic signed [23:0] new_first_vel_y,
  output logic signed [23:0] new_second_pos_x,
  output logic signed [23:0] new_second_pos_y,
  output logic signed [23:0] new_second_vel_x,
  output logic signed [23:0] new_second_vel_y,
  output logic               collided,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NSQ = ppc_pkg::RTW;
  localparam int NQ  = ppc_pkg::QW;

  logic [19:0] disc_radius;
  logic [8:0]  restitution;
  logic [20:0] contact_dist;

  assign busy         = 1'b0;
  assign pready       = 1'b1;
  assign contact_dist = {disc_radius, 1'b0};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disc_radius <= ppc_pkg::RADIUS_RESET;
      restitution <= ppc_pkg::REST_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (ppc_pkg::reg_idx_t'(paddr[2]))
        ppc_pkg::REG_DISC_RADIUS: disc_radius <= pwdata[19:0];
        ppc_pkg::REG_RESTITUTION: restitution <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ppc_pkg::reg_idx_t'(paddr[2]))
      ppc_pkg::REG_DISC_RADIUS: prdata = {12'b0, disc_radius};
      ppc_pkg::REG_RESTITUTION: prdata = {23'b0, restitution};
      default:                  prdata = '0;
    endcase
  end

  // stage 1: differences
  logic                  s1_v;
  ppc_pkg::discs_t       s1_d;
  logic signed [24:0]    s1_dx, s1_dy, s1_dvx, s1_dvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    s1_d   <= {first_pos_x, first_pos_y, first_vel_x, first_vel_y,
               second_pos_x, second_pos_y, second_vel_x, second_vel_y};
    s1_dx  <= first_pos_x - second_pos_x;
    s1_dy  <= first_pos_y - second_pos_y;
    s1_dvx <= first_vel_x - second_vel_x;
    s1_dvy <= first_vel_y - second_vel_y;
  end

  // stage 2: products
  logic                  s2_v;
  ppc_pkg::discs_t       s2_d;
  logic signed [24:0]    s2_dx, s2_dy;
  logic signed [49:0]    s2_xx, s2_yy, s2_ax, s2_ay;
  logic [41:0]           s2_mm;
  logic signed [49:0]    xx_w, yy_w, ax_w, ay_w;
  logic [41:0]           mm_w;

  assign xx_w = s1_dx * s1_dx;
  assign yy_w = s1_dy * s1_dy;
  assign ax_w = s1_dvx * s1_dx;
  assign ay_w = s1_dvy * s1_dy;
  assign mm_w = contact_dist * contact_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_d  <= s1_d;
    s2_dx <= s1_dx;
    s2_dy <= s1_dy;
    s2_xx <= xx_w;
    s2_yy <= yy_w;
    s2_ax <= ax_w;
    s2_ay <= ay_w;
    s2_mm <= mm_w;
  end

  // stage 3: squared distance, approach speed, contact test; feeds the root
  ppc_pkg::sq_t          sq  [0:NSQ];
  logic                  sqv [0:NSQ];
  logic [50:0]           d2_w;
  logic signed [50:0]    dot_w;
  logic                  ct_w;

  assign d2_w  = {1'b0, s2_xx} + {1'b0, s2_yy};
  assign dot_w = s2_ax + s2_ay;
  assign ct_w  = (d2_w != '0) && (d2_w < {9'b0, s2_mm}) && (dot_w[50] || dot_w == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else begin
      sqv[0] <= s2_v;
    end
    sq[0].d    <= s2_d;
    sq[0].dx   <= s2_dx;
    sq[0].dy   <= s2_dy;
    sq[0].ct   <= ct_w;
    sq[0].n    <= d2_w[41:0];
    sq[0].dot  <= dot_w[47:0];
    sq[0].rem  <= '0;
    sq[0].root <= '0;
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    ppc_pkg::sqs_t nx;
    ppc_pkg::sq_t  sq_next;
    assign nx = ppc_pkg::sqrt_step(sq[k].rem, sq[k].root, sq[k].n[ppc_pkg::D2W-1-2*k -: 2]);
    always_comb begin
      sq_next      = sq[k];
      sq_next.rem  = nx.rem;
      sq_next.root = nx.root;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else begin
        sqv[k+1] <= sqv[k];
      end
      sq[k+1] <= sq_next;
    end
  end

  // stage P: penetration, magnitudes
  logic                  p_v;
  ppc_pkg::discs_t       p_d;
  logic                  p_sx, p_sy, p_ct;
  logic [20:0]           p_dxm, p_dym, p_dnorm, p_pen;
  logic [47:0]           p_dotm;
  logic signed [24:0]    dxa_w, dya_w;
  logic signed [47:0]    dotn_w;

  assign dxa_w  = sq[NSQ].dx[24] ? -sq[NSQ].dx : sq[NSQ].dx;
  assign dya_w  = sq[NSQ].dy[24] ? -sq[NSQ].dy : sq[NSQ].dy;
  assign dotn_w = -sq[NSQ].dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= sqv[NSQ];
    end
    p_d     <= sq[NSQ].d;
    p_sx    <= sq[NSQ].dx[24];
    p_sy    <= sq[NSQ].dy[24];
    p_ct    <= sq[NSQ].ct;
    p_dxm   <= dxa_w[20:0];
    p_dym   <= dya_w[20:0];
    p_dnorm <= sq[NSQ].root;
    p_pen   <= contact_dist - sq[NSQ].root;
    p_dotm  <= dotn_w;
  end

  // divide segments: first gives normal speed and position corrections,
  // second gives the velocity impulses
  ppc_pkg::dv_t          dv  [0:1][0:NQ];
  logic                  dvv [0:1][0:NQ];
  logic [41:0]           pcx_w, pcy_w;

  assign pcx_w = p_pen * p_dxm;
  assign pcy_w = p_pen * p_dym;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0][0] <= 1'b0;
    end else begin
      dvv[0][0] <= p_v;
    end
    dv[0][0].d     <= p_d;
    dv[0][0].sx    <= p_sx;
    dv[0][0].sy    <= p_sy;
    dv[0][0].ct    <= p_ct;
    dv[0][0].dxm   <= p_dxm;
    dv[0][0].dym   <= p_dym;
    dv[0][0].dnorm <= p_dnorm;
    dv[0][0].cx    <= '0;
    dv[0][0].cy    <= '0;
    dv[0][0].n[0]  <= p_dotm;
    dv[0][0].r[0]  <= {1'b0, p_dotm[47:28]};
    dv[0][0].n[1]  <= {7'b0, pcx_w[41:1]};
    dv[0][0].r[1]  <= {8'b0, pcx_w[41:29]};
    dv[0][0].n[2]  <= {7'b0, pcy_w[41:1]};
    dv[0][0].r[2]  <= {8'b0, pcy_w[41:29]};
    dv[0][0].q     <= '0;
  end

  for (genvar s = 0; s < 2; s++) begin : g_seg
    for (genvar j = 0; j < NQ; j++) begin : g_div
      ppc_pkg::dvs_t st [ppc_pkg::NDIV];
      ppc_pkg::dv_t  dv_next;
      for (genvar i = 0; i < ppc_pkg::NDIV; i++) begin : g_lane
        assign st[i] = ppc_pkg::div_step(dv[s][j].r[i], dv[s][j].n[i][NQ-1-j], dv[s][j].dnorm);
      end
      always_comb begin
        dv_next = dv[s][j];
        for (int i = 0; i < ppc_pkg::NDIV; i++) begin
          dv_next.r[i] = st[i].r;
          dv_next.q[i] = {dv[s][j].q[i][NQ-2:0], st[i].qb};
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          dvv[s][j+1] <= 1'b0;
        end else begin
          dvv[s][j+1] <= dvv[s][j];
        end
        dv[s][j+1] <= dv_next;
      end
    end
  end

  // stage K: impulse scale
  logic                  k_v;
  ppc_pkg::discs_t       k_d;
  logic                  k_sx, k_sy, k_ct;
  logic [20:0]           k_dxm, k_dym, k_dnorm, k_cx, k_cy;
  logic [36:0]           k_k;
  logic [36:0]           k_w;

  assign k_w = dv[0][NQ].q[0][26:0] * (ppc_pkg::REST_ONE + {1'b0, restitution});

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else begin
      k_v <= dvv[0][NQ];
    end
    k_d     <= dv[0][NQ].d;
    k_sx    <= dv[0][NQ].sx;
    k_sy    <= dv[0][NQ].sy;
    k_ct    <= dv[0][NQ].ct;
    k_dxm   <= dv[0][NQ].dxm;
    k_dym   <= dv[0][NQ].dym;
    k_dnorm <= dv[0][NQ].dnorm;
    k_cx    <= dv[0][NQ].q[1][20:0];
    k_cy    <= dv[0][NQ].q[2][20:0];
    k_k     <= k_w;
  end

  // load second segment with k*|d| / 512
  logic [57:0] kx_w, ky_w;

  assign kx_w = k_k * k_dxm;
  assign ky_w = k_k * k_dym;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[1][0] <= 1'b0;
    end else begin
      dvv[1][0] <= k_v;
    end
    dv[1][0].d     <= k_d;
    dv[1][0].sx    <= k_sx;
    dv[1][0].sy    <= k_sy;
    dv[1][0].ct    <= k_ct;
    dv[1][0].dxm   <= k_dxm;
    dv[1][0].dym   <= k_dym;
    dv[1][0].dnorm <= k_dnorm;
    dv[1][0].cx    <= k_cx;
    dv[1][0].cy    <= k_cy;
    dv[1][0].n[0]  <= kx_w[56:9];
    dv[1][0].r[0]  <= {1'b0, kx_w[56:37]};
    dv[1][0].n[1]  <= ky_w[56:9];
    dv[1][0].r[1]  <= {1'b0, ky_w[56:37]};
    dv[1][0].n[2]  <= '0;
    dv[1][0].r[2]  <= '0;
    dv[1][0].q     <= '0;
  end

  // output stage: apply signs, update and saturate on contact; otherwise pass through
  ppc_pkg::dv_t          fe;
  logic signed [29:0]    ixs, iys, cxs, cys;
  logic signed [29:0]    sp1x, sp1y, sv1x, sv1y, sp2x, sp2y, sv2x, sv2y;

  assign fe = dv[1][NQ];

  always_comb begin
    ixs = fe.sx ? -$signed({2'b0, fe.q[0]}) : $signed({2'b0, fe.q[0]});
    iys = fe.sy ? -$signed({2'b0, fe.q[1]}) : $signed({2'b0, fe.q[1]});
    cxs = fe.sx ? -$signed({9'b0, fe.cx}) : $signed({9'b0, fe.cx});
    cys = fe.sy ? -$signed({9'b0, fe.cy}) : $signed({9'b0, fe.cy});
    sp1x = fe.d.p1x + cxs;
    sp1y = fe.d.p1y + cys;
    sv1x = fe.d.v1x + ixs;
    sv1y = fe.d.v1y + iys;
    sp2x = fe.d.p2x - cxs;
    sp2y = fe.d.p2y - cys;
    sv2x = fe.d.v2x - ixs;
    sv2y = fe.d.v2y - iys;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvv[1][NQ];
    end
    collided <= fe.ct;
    if (fe.ct) begin
      new_first_pos_x  <= ppc_pkg::sat(sp1x);
      new_first_pos_y  <= ppc_pkg::sat(sp1y);
      new_first_vel_x  <= ppc_pkg::sat(sv1x);
      new_first_vel_y  <= ppc_pkg::sat(sv1y);
      new_second_pos_x <= ppc_pkg::sat(sp2x);
      new_second_pos_y <= ppc_pkg::sat(sp2y);
      new_second_vel_x <= ppc_pkg::sat(sv2x);
      new_second_vel_y <= ppc_pkg::sat(sv2y);
    end else begin
      // pass through untouched
      new_first_pos_x  <= fe.d.p1x;
      new_first_pos_y  <= fe.d.p1y;
      new_first_vel_x  <= fe.d.v1x;
      new_first_vel_y  <= fe.d.v1y;
      new_second_pos_x <= fe.d.p2x;
      new_second_pos_y <= fe.d.p2y;
      new_second_vel_x <= fe.d.v2x;
      new_second_vel_y <= fe.d.v2y;
    end
  end

endmodule

// ===== tb/tb_particle_pair_collision_top.sv =====
// Self-checking testbench for the pipelined disc collision resolver.
`timescale 1ns / 1ps

module tb_particle_pair_collision_top;

  localparam int LATENCY     = 85;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [23:0] f[8];
  } pair_t;

  typedef struct {
    logic signed [23:0] f[8];
    logic               hit;
  } resolved_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] first_pos_x = '0, first_pos_y = '0, first_vel_x = '0, first_vel_y = '0;
  logic signed [23:0] second_pos_x = '0, second_pos_y = '0;
  logic signed [23:0] second_vel_x = '0, second_vel_y = '0;
  logic               done;
  logic signed [23:0] new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y;
  logic signed [23:0] new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y;
  logic               collided;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int        error_count = 0;
  int        cycle_count = 0;
  int        idle_pct = 0;
  logic [19:0] radius_q = ppc_pkg::RADIUS_RESET;
  logic [8:0]  rest_q = ppc_pkg::REST_RESET;
  resolved_t expected_q[$];

  particle_pair_collision_top DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_particle_pair_collision_top failed");
      $finish;
    end
  end

  function automatic logic signed [23:0] clamp24(longint x);
    if (x > 64'sd8388607) return 24'sh7FFFFF;
    if (x < -64'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic longint root_floor(longint n);
    longint r = 0;
    longint b = 64'sd1 << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // resolve one contact between two equal discs
  function automatic resolved_t resolve_contact(pair_t p);
    resolved_t res;
    longint v[8];
    longint dx, dy, d2, m, dot, root_d, vn, k, ix, iy, pen, cx, cy;
    for (int i = 0; i < 8; i++) v[i] = p.f[i];
    dx = v[0] - v[4];
    dy = v[1] - v[5];
    d2 = dx * dx + dy * dy;
    m = 2 * longint'(radius_q);
    res.hit = 1'b0;
    if (d2 > 0 && d2 < m * m) begin
      dot = (v[2] - v[6]) * dx + (v[3] - v[7]) * dy;
      if (dot <= 0) begin
        root_d = root_floor(d2);
        vn = dot / root_d;
        k = -vn * (256 + longint'(rest_q));
        ix = (k * dx) / (512 * root_d);
        iy = (k * dy) / (512 * root_d);
        pen = m - root_d;
        cx = (pen * dx) / (2 * root_d);
        cy = (pen * dy) / (2 * root_d);
        v[2] += ix; v[3] += iy; v[6] -= ix; v[7] -= iy;
        v[0] += cx; v[1] += cy; v[4] -= cx; v[5] -= cy;
        res.hit = 1'b1;
      end
    end
    for (int i = 0; i < 8; i++) res.f[i] = clamp24(v[i]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    resolved_t e;
    logic signed [23:0] got[8];
    if (!rst && done) begin
      got = '{new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
              new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_q.pop_front();
        for (int i = 0; i < 8; i++)
          if (got[i] !== e.f[i]) report_mismatch($sformatf("field %0d", i), got[i], e.f[i]);
        if (collided !== e.hit) report_mismatch("collided", collided, e.hit);
      end
    end
  end

  task automatic write_reg(ppc_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == ppc_pkg::REG_DISC_RADIUS) radius_q = value[19:0];
    else rest_q = value[8:0];
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    first_pos_x <= p.f[0]; first_pos_y <= p.f[1];
    first_vel_x <= p.f[2]; first_vel_y <= p.f[3];
    second_pos_x <= p.f[4]; second_pos_y <= p.f[5];
    second_vel_x <= p.f[6]; second_vel_y <= p.f[7];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(resolve_contact(p));
  endtask

  task automatic stop_sending;
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pair_t make_pair(logic signed [23:0] a[8]);
    pair_t p;
    p.f = a;
    return p;
  endfunction

  // contact-range pair with random content; span keeps each offset within about half the contact distance
  function automatic pair_t near_pair();
    pair_t p;
    int span = 2 * int'(radius_q) + 4;
    if (span > 8000000) span = 8000000;
    for (int i = 0; i < 8; i++) p.f[i] = 24'($urandom);
    p.f[0] = 24'($urandom_range(8000000)) - 24'sd4000000;
    p.f[1] = 24'($urandom_range(8000000)) - 24'sd4000000;
    p.f[4] = p.f[0] + 24'($urandom_range(span) - span / 2);
    p.f[5] = p.f[1] + 24'($urandom_range(span) - span / 2);
    if ($urandom_range(3) == 0)
      for (int i = 2; i < 8; i++) if (i != 4 && i != 5) p.f[i] = 24'($urandom_range(2000) - 1000);
    return p;
  endfunction

  function automatic pair_t noise_pair();
    pair_t p;
    for (int i = 0; i < 8; i++) p.f[i] = 24'($urandom);
    return p;
  endfunction

  task automatic test_directed;
    send_pair(make_pair('{0, 0, 0, 0, 0, 0, 0, 0}));               // coincident centres
    send_pair(make_pair('{0, 0, 256, 0, 1000, 0, 0, 0}));          // head-on approach
    send_pair(make_pair('{0, 0, -256, 0, 1000, 0, 0, 0}));         // separating
    send_pair(make_pair('{0, 0, 0, 256, 1000, 0, 0, 0}));          // touching motion
    send_pair(make_pair('{100, 200, 300, -400, 900, -700, -50, 60}));
    send_pair(make_pair('{8388607, 8388607, 8388607, 8388607,
                          8388000, 8388000, -8388608, -8388608}));
    send_pair(make_pair('{-8388608, -8388608, -8388608, -8388608,
                          -8388000, -8388000, 8388607, 8388607}));
    send_pair(make_pair('{0, 0, 8388607, 0, 1, 0, -8388608, 0}));  // huge impulse
    send_pair(make_pair('{0, 0, 0, 0, 2560, 0, 0, 0}));            // exactly at contact
    send_pair(make_pair('{0, 0, 0, 0, 2559, 0, 0, 0}));
    send_pair(make_pair('{-8388608, 0, 0, 0, 8388607, 0, 0, 0}));
    stop_sending();
    drain();
  endtask

  task automatic test_registers;
    write_reg(ppc_pkg::REG_DISC_RADIUS, 0);
    send_pair(make_pair('{0, 0, 256, 0, 10, 0, 0, 0}));            // zero radius
    stop_sending();
    drain();
    write_reg(ppc_pkg::REG_DISC_RADIUS, 32'hFFFFF);
    write_reg(ppc_pkg::REG_RESTITUTION, 511);                       // above elastic
    send_pair(make_pair('{0, 0, 8388607, 8388607, 2000000, 1000000, -8388608, 0}));
    send_pair(make_pair('{-4000000, 3000000, 5000, -9000, -3000000, 2500000, -7000, 6000}));
    stop_sending();
    drain();
    write_reg(ppc_pkg::REG_RESTITUTION, 0);
    send_pair(make_pair('{0, 0, 256, 0, 1000, 0, 0, 0}));
    stop_sending();
    drain();
  endtask

  task automatic test_random_phase(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++)
      send_pair(($urandom_range(9) < 8) ? near_pair() : noise_pair());
    stop_sending();
    drain();
  endtask

  task automatic test_random;
    logic [19:0] radii[4] = '{20'd1, 20'd1280, 20'd40000, 20'hFFFFF};
    logic [8:0]  rests[4] = '{9'd0, 9'd256, 9'd128, 9'd511};
    int          pcts[4]  = '{0, 83, 27, 0};
    for (int s = 0; s < 4; s++) begin
      write_reg(ppc_pkg::REG_DISC_RADIUS, 32'(radii[s]));
      write_reg(ppc_pkg::REG_RESTITUTION, 32'(rests[(s + 1) % 4]));
      test_random_phase(430, pcts[s]);
    end
    write_reg(ppc_pkg::REG_DISC_RADIUS, $urandom_range(20'hFFFFF, 1));
    write_reg(ppc_pkg::REG_RESTITUTION, $urandom_range(511));
    test_random_phase(40, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random();
    if (error_count == 0) begin
      $display("tb_particle_pair_collision_top passed");
    end else begin
      $display("tb_particle_pair_collision_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ppc_pkg.sv
sv/particle_pair_collision_top.sv
tb/tb_particle_pair_collision_top.sv
